FILE: rtl/mean_and_stddev_defines.svh
// Assertion macros for the port-level checker of the mean and deviation block.
`ifndef MEAN_AND_STDDEV_DEFINES_SVH
`define MEAN_AND_STDDEV_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define MSD_ASSERT_NOW(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define MSD_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/msd_pkg.sv
// Shared types, codes and field widths of the mean and deviation block.
package msd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MEAN_W   = 24;
    localparam int STD_W    = 24;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK,
        STATUS_TOO_FEW,
        STATUS_TOO_MANY
    } status_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_CHECK,
        ST_MEAN,
        ST_MUL_A,
        ST_MUL_B,
        ST_VAR,
        ST_ROOT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    take;
        logic    mean_start;
        logic    mean_load;
        logic    mac_load_a;
        logic    mac_load_b;
        logic    mac_step;
        logic    mac_sub;
        logic    var_start;
        logic    sqrt_start;
        logic    result_load;
        status_t res_status;
    } msd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic stage_last;
        logic overflow;
        logic too_few;
        logic div_busy;
        logic mac_busy;
        logic sqrt_busy;
    } msd_stat_t;

endpackage

FILE: rtl/msd_sample_if.sv
// Sample channel: valid/ready handshake with one sample and its last flag.
interface msd_sample_if
    import msd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink (input valid, input sample, input last_sample, output ready);
endinterface

FILE: rtl/msd_result_if.sv
// Result channel: valid/ready handshake with mean, deviation, count and status.
interface msd_result_if
    import msd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [MEAN_W-1:0]   mean;
    logic [STD_W-1:0]    std_dev;
    logic [COUNT_W-1:0]  sample_count;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output mean, output std_dev, output sample_count,
                    output status, input ready);
    modport sink (input valid, input mean, input std_dev, input sample_count,
                  input status, output ready);
endinterface

FILE: rtl/msd_div.sv
// Restoring divider: one quotient bit per cycle.
module msd_div
    import msd_pkg::*;
#(
    parameter int NUM_W = 72,
    parameter int DEN_W = 26
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;

    // Trial subtract of the divisor from the shifted remainder
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    // Load on start, then shift one numerator bit in per cycle
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

FILE: rtl/msd_sqrt.sv
// Digit-by-digit integer square root: one root bit per cycle.
module msd_sqrt
    import msd_pkg::*;
#(
    parameter int IN_W = 72
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [IN_W-1:0]     radicand,
    output logic                busy,
    output logic [IN_W/2-1:0]   root
);

    localparam int RW    = IN_W / 2;
    localparam int CNT_W = $clog2(RW + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IN_W-1:0]  rad_reg, rad_next;
    logic [RW-1:0]    root_reg, root_next;
    logic [RW+1:0]    rem_reg, rem_next;
    logic [RW+1:0]    rem_sh;
    logic [RW+1:0]    trial;
    logic             ge;

    // Bring down two radicand bits and try root*4+1
    assign rem_sh = {rem_reg[RW-1:0], rad_reg[IN_W-1:IN_W-2]};
    assign trial  = {root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(RW);
            rad_next  = radicand;
            root_next = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rad_next  = rad_reg << 2;
            root_next = {root_reg[RW-2:0], ge};
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

FILE: rtl/msd_datapath.sv
// Datapath: square stage, accumulators, serial multiplier, divider, root and result.
module msd_datapath
    import msd_pkg::*;
#(
    parameter int MAX_SAMPLES         = 4096,
    parameter int SAMPLE_BITS         = 16,
    parameter int EXTRA_FRACTION_BITS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  msd_cmd_t            cmd,
    output msd_stat_t           stat,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                last_sample,
    output logic [MEAN_W-1:0]   mean,
    output logic [STD_W-1:0]    std_dev,
    output logic [COUNT_W-1:0]  sample_count,
    output logic [STATUS_W-1:0] status
);

    localparam int CW      = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_SAMPLES);
    localparam int SQ_W    = 2 * SAMPLE_BITS - 1 + $clog2(MAX_SAMPLES);
    localparam int PW      = CW + SQ_W;
    localparam int NUM_W   = PW + 2 * EXTRA_FRACTION_BITS;
    localparam int DEN_W   = 2 * CW;
    localparam int SQ_IN_W = NUM_W + (NUM_W % 2);
    localparam int RW      = SQ_IN_W / 2;
    localparam int QX_W    = NUM_W + MEAN_W;
    localparam int RX_W    = RW + STD_W;

    localparam logic [QX_W-1:0] MEAN_NEG_LIM = QX_W'(1) << (MEAN_W - 1);
    localparam logic [QX_W-1:0] MEAN_POS_LIM = MEAN_NEG_LIM - QX_W'(1);
    localparam logic [RX_W-1:0] STD_MAX      = (RX_W'(1) << STD_W) - RX_W'(1);

    logic signed [SAMPLE_BITS-1:0]   sx;
    logic signed [2*SAMPLE_BITS-1:0] sq_full;

    logic                          st_vld_reg, st_vld_next;
    logic                          st_last_reg;
    logic signed [SAMPLE_BITS-1:0] st_sx_reg;
    logic [2*SAMPLE_BITS-2:0]      st_sq_reg;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]         sumsq_reg, sumsq_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    ovf_reg, ovf_next;

    logic [SUM_W-1:0] m_mag;
    logic             sum_neg;

    logic [PW-1:0]    mac_reg, mac_next;
    logic [PW-1:0]    mcand_reg, mcand_next;
    logic [SUM_W-1:0] mplier_reg, mplier_next;

    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [DEN_W-1:0] nn1;
    logic             div_busy;
    logic [NUM_W-1:0] div_quo;

    logic          sqrt_busy;
    logic [RW-1:0] sqrt_root;

    logic [QX_W-1:0]   quo_x;
    logic [MEAN_W-1:0] mean_mag;
    logic [MEAN_W-1:0] mean_val;
    logic [MEAN_W-1:0] mean_tmp_reg;
    logic [RX_W-1:0]   root_x;
    logic [STD_W-1:0]  std_val;

    logic [MEAN_W-1:0]  res_mean_reg;
    logic [STD_W-1:0]   res_std_reg;
    logic [COUNT_W-1:0] res_count_reg;
    status_t            res_status_reg;

    // Take the low sample bits as two's complement; wider samples zero-extend
    if (SAMPLE_BITS <= SAMPLE_W)
    begin : g_narrow
        assign sx = $signed(sample[SAMPLE_BITS-1:0]);
    end
    else
    begin : g_wide
        assign sx = $signed(SAMPLE_BITS'(sample));
    end

    assign sq_full = sx * sx;

    // Square stage: register the sample and its square
    assign st_vld_next = cmd.take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_vld_reg <= 1'b0;
        end
        else
        begin
            st_vld_reg <= st_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            st_last_reg <= last_sample;
            st_sx_reg   <= sx;
            st_sq_reg   <= sq_full[2*SAMPLE_BITS-2:0];
        end
    end

    // Accumulate, drop samples past the bound, clear once the result is loaded
    always_comb
    begin
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.result_load)
        begin
            sum_next   = '0;
            sumsq_next = '0;
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (st_vld_reg)
        begin
            if (count_reg >= CW'(MAX_SAMPLES))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                sum_next   = sum_reg + SUM_W'(st_sx_reg);
                sumsq_next = sumsq_reg + SQ_W'(st_sq_reg);
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            sumsq_reg <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            sumsq_reg <= sumsq_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign sum_neg = sum_reg[SUM_W-1];
    assign m_mag   = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    // Shift-add multiplier: n*sumsq first, then subtract |sum|^2
    always_comb
    begin
        mac_next    = mac_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (cmd.mac_load_a)
        begin
            mac_next    = '0;
            mcand_next  = PW'(sumsq_reg);
            mplier_next = SUM_W'(count_reg);
        end
        else if (cmd.mac_load_b)
        begin
            mcand_next  = PW'(m_mag);
            mplier_next = m_mag;
        end
        else if (cmd.mac_step)
        begin
            if (mplier_reg[0])
            begin
                mac_next = cmd.mac_sub ? (mac_reg - mcand_reg) : (mac_reg + mcand_reg);
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        mac_reg    <= mac_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    // Shared divider: scaled |sum| / n, then scaled difference / (n*(n-1))
    assign nn1       = count_reg * (count_reg - CW'(1));
    assign div_start = cmd.mean_start | cmd.var_start;
    assign div_num   = cmd.var_start ? (NUM_W'(mac_reg) << (2 * EXTRA_FRACTION_BITS))
                                     : (NUM_W'(m_mag) << EXTRA_FRACTION_BITS);
    assign div_den   = cmd.var_start ? nn1 : DEN_W'(count_reg);

    msd_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    msd_sqrt #(
        .IN_W (SQ_IN_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (SQ_IN_W'(div_quo)),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    // Saturate the mean magnitude, then restore the sign
    assign quo_x = QX_W'(div_quo);

    always_comb
    begin
        if (sum_neg)
        begin
            mean_mag = (quo_x > MEAN_NEG_LIM) ? MEAN_W'(MEAN_NEG_LIM) : MEAN_W'(quo_x);
        end
        else
        begin
            mean_mag = (quo_x > MEAN_POS_LIM) ? MEAN_W'(MEAN_POS_LIM) : MEAN_W'(quo_x);
        end
    end

    assign mean_val = sum_neg ? MEAN_W'(~mean_mag + MEAN_W'(1)) : mean_mag;

    // Saturate the deviation
    assign root_x  = RX_W'(sqrt_root);
    assign std_val = (root_x > STD_MAX) ? STD_W'(STD_MAX) : STD_W'(root_x);

    // Hold the mean while the deviation is worked out; load the result
    always_ff @(posedge clk)
    begin
        if (cmd.mean_load)
        begin
            mean_tmp_reg <= mean_val;
        end
        if (cmd.result_load)
        begin
            res_count_reg  <= COUNT_W'(count_reg);
            res_status_reg <= cmd.res_status;
            if (cmd.res_status == STATUS_OK)
            begin
                res_mean_reg <= mean_tmp_reg;
                res_std_reg  <= std_val;
            end
            else
            begin
                res_mean_reg <= '0;
                res_std_reg  <= '0;
            end
        end
    end

    assign stat.stage_last = st_vld_reg & st_last_reg;
    assign stat.overflow   = ovf_reg;
    assign stat.too_few    = count_reg < CW'(2);
    assign stat.div_busy   = div_busy;
    assign stat.mac_busy   = mplier_reg != '0;
    assign stat.sqrt_busy  = sqrt_busy;

    assign mean         = res_mean_reg;
    assign std_dev      = res_std_reg;
    assign sample_count = res_count_reg;
    assign status       = res_status_reg;

endmodule

FILE: rtl/msd_ctrl.sv
// Controller: handshakes and the sequence of steps that closes each set.
module msd_ctrl
    import msd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  msd_stat_t stat,
    output msd_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   ready;

    always_comb
    begin
        cmd            = '0;
        cmd.res_status = STATUS_OK;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        ready          = 1'b0;

        // Drop the result once its transaction completes
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_ACCUM:
            begin
                ready    = !stat.stage_last;
                cmd.take = in_valid && ready;
                if (stat.stage_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // Wait for the result slot to free up
                if (!out_valid_reg)
                begin
                    if (stat.overflow)
                    begin
                        cmd.result_load = 1'b1;
                        cmd.res_status  = STATUS_TOO_MANY;
                        out_valid_next  = 1'b1;
                        state_next      = ST_ACCUM;
                    end
                    else if (stat.too_few)
                    begin
                        cmd.result_load = 1'b1;
                        cmd.res_status  = STATUS_TOO_FEW;
                        out_valid_next  = 1'b1;
                        state_next      = ST_ACCUM;
                    end
                    else
                    begin
                        cmd.mean_start = 1'b1;
                        state_next     = ST_MEAN;
                    end
                end
            end
            ST_MEAN:
            begin
                if (!stat.div_busy)
                begin
                    cmd.mean_load  = 1'b1;
                    cmd.mac_load_a = 1'b1;
                    state_next     = ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                if (stat.mac_busy)
                begin
                    cmd.mac_step = 1'b1;
                end
                else
                begin
                    cmd.mac_load_b = 1'b1;
                    state_next     = ST_MUL_B;
                end
            end
            ST_MUL_B:
            begin
                if (stat.mac_busy)
                begin
                    cmd.mac_step = 1'b1;
                    cmd.mac_sub  = 1'b1;
                end
                else
                begin
                    cmd.var_start = 1'b1;
                    state_next    = ST_VAR;
                end
            end
            ST_VAR:
            begin
                if (!stat.div_busy)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (!stat.sqrt_busy)
                begin
                    cmd.result_load = 1'b1;
                    cmd.res_status  = STATUS_OK;
                    out_valid_next  = 1'b1;
                    state_next      = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = ready;
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/mean_and_stddev.sv
// Throughput: one sample per cycle while a set accumulates (square stage, then accumulate).
// Closing a set: a short set or one over the bound gets its status result from the check
// once the result slot is free; otherwise the mean division, the two multiplier passes,
// the variance division and the root run in turn, on the bit-serial divider and root.
// Samples of the next set are taken while the previous result waits on the output.
// Asynchronous active-low reset clears accumulators, sequencer and output valid.
module mean_and_stddev
    import msd_pkg::*;
#(
    parameter int MAX_SAMPLES         = 4096,
    parameter int SAMPLE_BITS         = 16,
    parameter int EXTRA_FRACTION_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    msd_sample_if.sink  samples,
    msd_result_if.source stats
);

    msd_cmd_t  cmd;
    msd_stat_t stat;

    msd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (stats.valid),
        .out_ready (stats.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    msd_datapath #(
        .MAX_SAMPLES         (MAX_SAMPLES),
        .SAMPLE_BITS         (SAMPLE_BITS),
        .EXTRA_FRACTION_BITS (EXTRA_FRACTION_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .sample       (samples.sample),
        .last_sample  (samples.last_sample),
        .mean         (stats.mean),
        .std_dev      (stats.std_dev),
        .sample_count (stats.sample_count),
        .status       (stats.status)
    );

endmodule

FILE: rtl/msd_checker.sv
// Port-level checker for the mean and deviation block, with its bind.
`include "mean_and_stddev_defines.svh"

module msd_checker
    import msd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                in_last,
    input logic                out_valid,
    input logic                out_ready,
    input logic [MEAN_W-1:0]   mean,
    input logic [STD_W-1:0]    std_dev,
    input logic [COUNT_W-1:0]  sample_count,
    input logic [STATUS_W-1:0] status
);

    // One result per set: nothing follows right after a result transaction
    `MSD_ASSERT_NEXT(a_single_result, clk, rst_n, out_valid && out_ready, !out_valid, "result repeated")

    // A set's last sample stalls input until its result is loaded
    `MSD_ASSERT_NEXT(a_last_stalls, clk, rst_n, in_valid && in_ready && in_last, !in_ready, "sample taken after last")

    // Error results carry zero mean and deviation
    `MSD_ASSERT_NOW(a_error_zero, clk, rst_n, out_valid && (status != STATUS_OK), (mean == '0) && (std_dev == '0), "error result not zeroed")

    // A short-set result has fewer than two samples
    `MSD_ASSERT_NOW(a_too_few_count, clk, rst_n, out_valid && (status == STATUS_TOO_FEW), sample_count < COUNT_W'(2), "short-set count wrong")

    // A stalled result holds
    `MSD_ASSERT_NEXT(a_result_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(mean) && $stable(std_dev) && $stable(status), "stalled result changed")

endmodule

bind mean_and_stddev msd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (samples.valid),
    .in_ready     (samples.ready),
    .in_last      (samples.last_sample),
    .out_valid    (stats.valid),
    .out_ready    (stats.ready),
    .mean         (stats.mean),
    .std_dev      (stats.std_dev),
    .sample_count (stats.sample_count),
    .status       (stats.status)
);

FILE: tb/msd_checker.sv
// Checker for the mean and deviation block: predicts each set's statistics and compares results.
`timescale 1ns / 100ps
module msd_scoreboard
    import msd_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096,
    parameter int FRAC_BITS   = 8
)
(
    input  logic  clk,
    input  logic  rst_n,
    msd_sample_if samples,
    msd_result_if stats,
    output int    errors,
    output int    pending
);

    typedef struct packed {
        logic [MEAN_W-1:0]  mean;
        logic [STD_W-1:0]   std_dev;
        logic [COUNT_W-1:0] sample_count;
        status_t            status;
    } set_stats_t;

    // Running state of the set being collected
    logic signed [27:0] sum_acc;
    logic [42:0]        square_acc;
    logic [COUNT_W-1:0] count_acc;
    logic               over_bound;

    // Statistics owed by the block, oldest first
    set_stats_t stats_due[$];

    // Largest root whose square does not exceed x
    function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
        logic [31:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = 64'(root | (32'd1 << b));
            if (trial * trial <= x)
                root = trial[31:0];
        end
        return root;
    endfunction

    // Close the current set: mean truncated toward zero, sample deviation rounded down
    function automatic set_stats_t set_statistics();
        set_stats_t         res;
        logic signed [63:0] sum_wide;
        logic [63:0]        mag;
        logic [63:0]        quo;
        logic [63:0]        lim;
        logic [63:0]        var_q;
        logic [127:0]       n_sq;
        logic [127:0]       sum_sq;
        logic [127:0]       spread;
        logic [127:0]       scaled;
        logic [31:0]        root;
        logic               neg;
        res.sample_count = count_acc;
        res.mean         = '0;
        res.std_dev      = '0;
        res.status       = STATUS_OK;
        if (over_bound)
            res.status = STATUS_TOO_MANY;
        else if (count_acc < 2)
            res.status = STATUS_TOO_FEW;
        else
        begin
            sum_wide = sum_acc;
            neg      = sum_wide < 0;
            mag      = neg ? -sum_wide : sum_wide;
            quo      = (mag << FRAC_BITS) / 64'(count_acc);
            lim      = 64'd1 << (MEAN_W - 1);
            // Saturate the mean to the signed output range
            if (neg)
            begin
                if (quo > lim)
                    quo = lim;
                res.mean = MEAN_W'(-quo);
            end
            else
            begin
                if (quo > lim - 64'd1)
                    quo = lim - 64'd1;
                res.mean = MEAN_W'(quo);
            end
            // Spread n*sumsq - sum^2, clamped at zero, scaled and divided exactly
            n_sq   = 128'(count_acc) * 128'(square_acc);
            sum_sq = 128'(mag) * 128'(mag);
            spread = (n_sq > sum_sq) ? n_sq - sum_sq : '0;
            scaled = (spread << (2 * FRAC_BITS)) /
                     (128'(count_acc) * (128'(count_acc) - 128'd1));
            var_q  = (scaled[127:64] != '0) ? '1 : scaled[63:0];
            root   = floor_sqrt(var_q);
            res.std_dev = (root > 32'((1 << STD_W) - 1)) ? '1 : root[STD_W-1:0];
        end
        return res;
    endfunction

    // Accumulate one sample; drop it once the set holds the bound
    task automatic absorb_sample(input logic [SAMPLE_W-1:0] raw, input logic last);
        logic signed [SAMPLE_W-1:0] value;
        logic signed [31:0]         square;
        value  = raw;
        square = value * value;
        if (count_acc >= COUNT_W'(MAX_SAMPLES))
            over_bound = 1'b1;
        else
        begin
            sum_acc    = sum_acc + value;
            square_acc = square_acc + 43'(square);
            count_acc  = count_acc + 1'b1;
        end
        if (last)
        begin
            stats_due.insert(stats_due.size(), set_statistics());
            sum_acc    = '0;
            square_acc = '0;
            count_acc  = '0;
            over_bound = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what);
        if (errors < 50)
            $display("%0t ns: mismatch: %s", $time, what);
        errors++;
    endtask

    // Compare one result transaction against the oldest prediction
    task automatic check_result();
        set_stats_t want;
        if (stats_due.size() == 0)
        begin
            report_mismatch($sformatf("result with no set pending (count %0d)",
                                      stats.sample_count));
            return;
        end
        want = stats_due.pop_front();
        if (stats.mean !== want.mean)
            report_mismatch($sformatf("mean %0d, expected %0d",
                                      $signed(stats.mean), $signed(want.mean)));
        if (stats.std_dev !== want.std_dev)
            report_mismatch($sformatf("std_dev %0d, expected %0d",
                                      stats.std_dev, want.std_dev));
        if (stats.sample_count !== want.sample_count)
            report_mismatch($sformatf("sample_count %0d, expected %0d",
                                      stats.sample_count, want.sample_count));
        if (stats.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      stats.status, want.status));
    endtask

    // Watch both channels; results first, then the incoming sample
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_acc    = '0;
            square_acc = '0;
            count_acc  = '0;
            over_bound = 1'b0;
            stats_due.delete();
            pending    = 0;
        end
        else
        begin
            if (stats.valid && stats.ready)
                check_result();
            if (samples.valid && samples.ready)
                absorb_sample(samples.sample, samples.last_sample);
            pending = stats_due.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
// Top of the mean and deviation testbench: clock, reset, sample sets, idling, stalling and verdict.
`timescale 1ns / 100ps
module tb_top;
    import msd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    typedef enum int {
        KIND_WIDE,
        KIND_NEAR,
        KIND_EDGE,
        KIND_FLAT
    } set_kind_t;

    logic clk = 1'b0;
    logic rst_n;
    int   idle_pct  = 0;
    int   stall_pct = 0;
    int   quiet_cycles = 0;
    int   err_count;
    int   pending_count;

    msd_sample_if samples();
    msd_result_if stats();

    mean_and_stddev dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .stats   (stats)
    );

    msd_scoreboard chk
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .stats   (stats),
        .errors  (err_count),
        .pending (pending_count)
    );

    always #1 clk = ~clk;

    // Stall the result channel at the current rate
    always @(posedge clk)
    begin
        stats.ready <= ($urandom_range(99) >= stall_pct);
    end

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (samples.valid && samples.ready) || (stats.valid && stats.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample(input set_kind_t kind,
                                                        input logic [SAMPLE_W-1:0] center);
        case (kind)
            KIND_WIDE: return SAMPLE_W'($urandom);
            KIND_NEAR: return center + SAMPLE_W'($urandom_range(64)) - 16'd32;
            KIND_EDGE:
            begin
                case ($urandom_range(3))
                    0:       return 16'h8000;
                    1:       return 16'h7fff;
                    2:       return 16'h0000;
                    default: return 16'hffff;
                endcase
            end
            default:   return center;
        endcase
    endfunction

    // Offer one sample transaction, idling first at the current rate
    task automatic send_item(input logic [SAMPLE_W-1:0] value, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            samples.valid  <= 1'b0;
            samples.sample <= SAMPLE_W'($urandom);
            @(posedge clk);
        end
        samples.valid       <= 1'b1;
        samples.sample      <= value;
        samples.last_sample <= last;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
    endtask

    task automatic send_set(input int len, input set_kind_t kind,
                            input logic [SAMPLE_W-1:0] center);
        for (int i = 0; i < len; i++)
            send_item(pick_sample(kind, center), i == len - 1);
    endtask

    // Hold off until every owed result has come out
    task automatic wait_drained();
        samples.valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Random sets, mostly short, sometimes long, now and then a single sample
    task automatic run_random(input int quota);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                len = 1;
            else if (pick < 75)
                len = $urandom_range(10, 2);
            else if (pick < 95)
                len = $urandom_range(40, 11);
            else
                len = $urandom_range(150, 41);
            send_set(len, set_kind_t'($urandom_range(3)), SAMPLE_W'($urandom));
            sent += len;
            if ($urandom_range(19) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        samples.valid       <= 1'b0;
        samples.sample      <= '0;
        samples.last_sample <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Single-sample sets at both extremes
        send_item(16'h7fff, 1'b1);
        send_item(16'h8000, 1'b1);
        // Pairs: flat at each extreme, then the widest spread; then a flat set of three zeros
        send_set(2, KIND_FLAT, 16'h8000);
        send_set(2, KIND_FLAT, 16'h7fff);
        send_item(16'h8000, 1'b0);
        send_item(16'h7fff, 1'b1);
        send_set(3, KIND_FLAT, 16'h0000);
        // Mean truncation toward zero on both signs
        send_item(16'hffff, 1'b0);
        send_item(16'hffff, 1'b0);
        send_item(16'h0000, 1'b1);
        send_item(16'h0001, 1'b0);
        send_item(16'h0001, 1'b0);
        send_item(16'h0000, 1'b1);

        // No idling
        run_random(90);
        wait_drained();

        idle_pct  = 88;
        stall_pct = 0;
        run_random(90);
        wait_drained();

        idle_pct  = 0;
        stall_pct = 88;
        run_random(90);
        wait_drained();

        idle_pct  = 24;
        stall_pct = 24;
        run_random(90);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/msd_pkg.sv
rtl/msd_sample_if.sv
rtl/msd_result_if.sv
rtl/msd_div.sv
rtl/msd_sqrt.sv
rtl/msd_datapath.sv
rtl/msd_ctrl.sv
rtl/mean_and_stddev.sv
rtl/msd_checker.sv
tb/msd_checker.sv
tb/tb_top.sv
